// ===== design/mexp_pkg.sv =====
package mexp_pkg;
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RED  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} mexp_state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mul_ctrl_t;
endpackage

// ===== design/mexp_modmul.sv =====
module mexp_modmul #(
	parameter int W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mexp_pkg::mul_ctrl_t ctrl_in,
	input  logic [W-1:0]        a,
	input  logic [W-1:0]        b,
	input  logic [W-1:0]        m,
	output mexp_pkg::mul_ctrl_t ctrl_out,
	output logic [W-1:0]        p
);
	import mexp_pkg::*;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] a_q;
	logic [W-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [W+1:0] dbl;
	logic [W+1:0] dred;
	logic [W+1:0] add;
	logic [W+1:0] ared;

	// msb-first shift-and-add, reduced each bit; acc < m always
	always_comb begin
		dbl = {2'b00, acc_q} << 1;
		dred = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
		add = dred + (a_q[W-1] ? {2'b00, b} : '0);
		ared = (add >= {2'b00, m}) ? add - {2'b00, m} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl_in.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_in.start) begin
			a_q <= a;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			acc_q <= ared[W-1:0];
		end
	end

	assign ctrl_out = '{start: 1'b0, busy: busy_q, done: done_q};
	assign p = acc_q;
endmodule

// ===== design/modular_exponentiation.sv =====
// modular exponentiation: power_mod = base ** exponent mod modulus
// input channel: valid / stall with base and exponent; output channel:
// valid / stall with power_mod. one result for each item.
// config channel: cfg_valid / cfg_ready carries the modulus, written only
// while idle; cfg_ready is high whenever no item is in flight.
// the base is first reduced bit-serially, one base bit a cycle, then
// square-and-multiply runs over all EXP_WIDTH exponent bits, msb first.
// each modular multiply is launched, runs MOD_WIDTH+1 shift-and-add steps
// and then has its product collected. a square always runs, a multiply
// only for set bits.
// one item is processed at a time; the result sits in an output register
// and stall holds it there, and the next item is taken only after the
// result leaves.
// reset clears control and loads the modulus 1000000007.
// modulus of zero gives 0; modulus of one gives 0.
module modular_exponentiation #(
	parameter int MOD_WIDTH = 31,
	parameter int EXP_WIDTH = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          base,
	input  logic [EXP_WIDTH-1:0] exponent,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [MOD_WIDTH-1:0] power_mod,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MOD_WIDTH-1:0] modulus
);
	import mexp_pkg::*;
	localparam int W = MOD_WIDTH + 1;
	localparam int EW = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;
	localparam int RW = $clog2(33);
	localparam longint RST_MOD = 64'd1000000007 & ((64'd1 << MOD_WIDTH) - 64'd1);

	mexp_state_t state_q;
	logic [MOD_WIDTH-1:0] mod_q;
	logic [W-1:0] m;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [EW-1:0] bit_q;
	logic sq_q;
	logic launched_q;
	logic [31:0] bsh_q;
	logic [W-1:0] rem_q;
	logic [RW-1:0] rcnt_q;
	logic [W-1:0] b_q;
	logic [W-1:0] acc_q;
	logic [MOD_WIDTH-1:0] res_q;
	logic [W:0] rsh;
	mul_ctrl_t mc_in;
	mul_ctrl_t mc_out;
	logic [W-1:0] ma;
	logic [W-1:0] mb;
	logic [W-1:0] mp;

	assign m = {1'b0, mod_q};
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign power_mod = res_q;
	assign rsh = {rem_q, bsh_q[31]};
	assign ma = acc_q;
	assign mb = sq_q ? acc_q : b_q;
	assign mc_in = '{start: (state_q == ST_MUL) && !launched_q, busy: 1'b0, done: 1'b0};

	mexp_modmul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctrl_in(mc_in),
		.a(ma), .b(mb), .m(m), .ctrl_out(mc_out), .p(mp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mod_q <= MOD_WIDTH'(RST_MOD);
			launched_q <= 1'b0;
			rcnt_q <= '0;
			bit_q <= '0;
			sq_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) mod_q <= modulus;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RED;
						rcnt_q <= RW'(32);
					end
				end
				ST_RED: begin
					rcnt_q <= rcnt_q - 1'b1;
					if (rcnt_q == RW'(1)) begin
						state_q <= (mod_q == '0) ? ST_DONE : ST_MUL;
						bit_q <= EW'(EXP_WIDTH - 1);
						sq_q <= 1'b1;
						launched_q <= 1'b0;
					end
				end
				ST_MUL: begin
					if (!launched_q) launched_q <= 1'b1;
					else if (mc_out.done) begin
						launched_q <= 1'b0;
						if (sq_q && exp_q[bit_q]) sq_q <= 1'b0;
						else begin
							sq_q <= 1'b1;
							if (bit_q == '0) state_q <= ST_DONE;
							else bit_q <= bit_q - 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				bsh_q <= base;
				exp_q <= exponent;
				rem_q <= '0;
			end
			ST_RED: begin
				bsh_q <= bsh_q << 1;
				if (rsh >= {1'b0, m}) rem_q <= W'(rsh - {1'b0, m});
				else rem_q <= rsh[W-1:0];
				if (rcnt_q == RW'(1)) begin
					b_q <= (rsh >= {1'b0, m}) ? W'(rsh - {1'b0, m}) : rsh[W-1:0];
					acc_q <= (mod_q == MOD_WIDTH'(1)) ? '0 : W'(1);
					res_q <= '0;
				end
			end
			ST_MUL: begin
				if (launched_q && mc_out.done) begin
					acc_q <= mp;
					res_q <= mp[MOD_WIDTH-1:0];
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== verif/mexp_checker.sv =====
module mexp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] base,
	input  logic [62:0] exponent,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [30:0] power_mod,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [30:0] modulus,
	output int          errors,
	output int          pending
);
	localparam int DEPTH = 4;

	logic [30:0] cur_modulus;
	logic [30:0] expected_mem[DEPTH];
	logic [1:0]  wr_ptr;
	logic [1:0]  rd_ptr;
	int          count;
	logic [30:0] exp_val;

	function automatic logic [30:0] predict_power(logic [31:0] b, logic [62:0] e,
			logic [30:0] m);
		longint unsigned mm;
		longint unsigned bb;
		longint unsigned acc;
		mm = 64'(m);
		if (mm == 0)
			return '0;
		bb = 64'(b) % mm;
		acc = 1 % mm;
		for (int i = 62; i >= 0; i--) begin
			acc = (acc * acc) % mm;
			if (e[i])
				acc = (acc * bb) % mm;
		end
		return acc[30:0];
	endfunction

	assign pending = count;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_modulus = 31'd1000000007;
			errors = 0;
			wr_ptr = '0;
			rd_ptr = '0;
			count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cur_modulus = modulus;
			if (in_valid && !in_stall) begin
				if (count == DEPTH) begin
					errors++;
					$display("%0t: item accepted while %0d results outstanding", $time, count);
				end else begin
					expected_mem[wr_ptr] = predict_power(base, exponent, cur_modulus);
					wr_ptr = wr_ptr + 2'd1;
					count++;
				end
			end
			if (out_valid && !out_stall) begin
				if (count == 0) begin
					errors++;
					$display("%0t: unexpected power_mod %0d", $time, power_mod);
				end else begin
					exp_val = expected_mem[rd_ptr];
					rd_ptr = rd_ptr + 2'd1;
					count--;
					if (power_mod !== exp_val) begin
						errors++;
						$display("%0t: power_mod expected %0d actual %0d", $time, exp_val,
							power_mod);
					end
				end
			end
		end
	end
endmodule

// ===== verif/tb_modular_exponentiation.sv =====
module tb_modular_exponentiation;
	localparam int WATCHDOG_LIMIT = 30000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] base = '0;
	logic [62:0] exponent = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [30:0] power_mod;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [30:0] modulus = '0;
	int          errors;
	int          pending;
	int          idle_cycles = 0;
	logic        sending_done = 1'b0;

	always #10 clk = ~clk;

	modular_exponentiation u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .base(base), .exponent(exponent),
		.out_valid(out_valid), .out_stall(out_stall), .power_mod(power_mod),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .modulus(modulus)
	);

	mexp_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .base(base), .exponent(exponent),
		.out_valid(out_valid), .out_stall(out_stall), .power_mod(power_mod),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .modulus(modulus),
		.errors(errors), .pending(pending)
	);

	function automatic int pick_gap();
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3);
	endfunction

	task automatic send_item(logic [31:0] b, logic [62:0] e);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		exponent <= e;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_modulus(logic [30:0] m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		modulus <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random(int count, logic [30:0] m);
		logic [31:0] b;
		logic [62:0] e;
		for (int i = 0; i < count; i++) begin
			b = $urandom;
			e = 63'({$urandom, $urandom});
			case ($urandom_range(5))
				0: e = '0;
				1: e = 63'($urandom_range(20));
				2: b = 32'(m + $urandom_range(2));
				3: b = $urandom_range(3);
				default: ;
			endcase
			send_item(b, e);
		end
	endtask

	// receiver side, with one long hold-off so the block backs up
	initial begin
		int n;
		n = 0;
		forever begin
			n++;
			if (n == 30) begin
				out_stall <= 1'b1;
				repeat (6000) @(posedge clk);
			end else if ($urandom_range(3) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(200, 50)) @(posedge clk);
			end else begin
				out_stall <= 1'($urandom_range(1));
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		logic [30:0] moduli[8];
		moduli = '{31'd2, 31'h7fffffff, 31'd3, 31'd1, 31'd0, 31'd0, 31'd0,
			31'd1000000007};
		moduli[5] = 31'($urandom);
		moduli[6] = 31'($urandom_range(1000, 2));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed items on the reset modulus
		send_item(32'd0, 63'd0);
		send_item(32'd0, 63'd5);
		send_item(32'hffffffff, 63'd0);
		send_item(32'hffffffff, '1);
		send_item(32'd1, '1);
		send_item(32'd2, 63'd1);
		send_item(32'd2, 63'd2);
		send_item(32'd1000000007, 63'd3);
		send_item(32'd1000000006, 63'd1000000005);
		send_item(32'h12345678, 63'h5555555555555555);
		send_item(32'hdeadbeef, 63'h2aaaaaaaaaaaaaaa);
		send_item(32'd1000000008, 63'h4000000000000000);
		foreach (moduli[k]) begin
			write_modulus(moduli[k]);
			send_item(32'hffffffff, '1);
			send_item(32'd7, 63'd0);
			send_random(16, moduli[k]);
		end
		in_valid <= 1'b0;
		sending_done <= 1'b1;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
